>>> rtl/core/tqmps_pkg.sv
// Package for the multi-policy task queue: field structs, codes, sizes.
// No dependencies.
`default_nettype none
package tqmps_pkg;
    localparam int DEPTH = 16;
    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int WGT_W = 20;

    localparam logic [2:0] POL_NEWEST = 3'd0;
    localparam logic [2:0] POL_OLDEST = 3'd1;
    localparam logic [2:0] POL_PRIO   = 3'd2;
    localparam logic [2:0] POL_LEVEL  = 3'd3;
    localparam logic [2:0] POL_WEIGHT = 3'd4;

    localparam logic [1:0] REG_POLICY = 2'd0;
    localparam logic [1:0] REG_HIGH   = 2'd1;
    localparam logic [1:0] REG_MID    = 2'd2;

    localparam logic [1:0] ST_DONE  = 2'd0;
    localparam logic [1:0] ST_NONE  = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    localparam logic CMD_PUSH = 1'b0;
    localparam logic CMD_POP  = 1'b1;

    typedef struct packed {
        logic        cmd;
        logic [15:0] task_id;
        logic [7:0]  priority_req;
        logic [7:0]  sub_count;
        logic [7:0]  proc_need;
        logic [15:0] mem_need;
        logic [15:0] disk_need;
        logic        has_resource;
    } in_beat_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] out_id;
        logic [7:0]  out_priority;
    } out_beat_t;

    typedef struct packed {
        logic [15:0]      id;
        logic [7:0]       prio;
        logic             has_res;
        logic [WGT_W-1:0] weight;
    } entry_t;

    typedef enum logic [2:0] {
        S_IDLE, S_WGT, S_SCAN, S_SHIFT, S_OUT
    } state_t;
endpackage
`default_nettype wire

>>> rtl/core/tqmps_ram.sv
// Single-port-write, single-read synchronous RAM with a registered read.
// Depends on nothing.
`default_nettype none
module tqmps_ram #(
    parameter int AW = 4,
    parameter int DW = 45
) (
    input  wire logic          clk,
    input  wire logic          we,
    input  wire logic [AW-1:0] waddr,
    input  wire logic [DW-1:0] wdata,
    input  wire logic [AW-1:0] raddr,
    output logic      [DW-1:0] rdata
);
    logic [DW-1:0] mem [2**AW];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

>>> rtl/core/task_queue_multi_policy_select.sv
// Multi-policy task queue top level: sequencer around the entry RAM.
// Depends on tqmps_pkg and tqmps_ram.
//
// One beat at a time. A push passes through the weight sum and RAM write, then
// the output stage, before its result beat. A dropped push or a pop of an empty
// table goes straight to the output stage. A pop scans the table through the
// single RAM read port, one entry per cycle, then closes the gap by copying the
// later entries down one per cycle, then passes the output stage. The input is
// stalled while a result beat waits in the output register, so the next beat is
// taken only after the result has been taken.
`default_nettype none
module task_queue_multi_policy_select (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_stall,
    input  wire tqmps_pkg::in_beat_t  in_data,
    output logic                      out_valid,
    input  wire logic                 out_stall,
    output tqmps_pkg::out_beat_t      out_data,
    input  wire logic                 cfg_we,
    input  wire logic [1:0]           cfg_index,
    input  wire logic [7:0]           cfg_data
);
    import tqmps_pkg::*;

    state_t state_reg, state_next;
    logic [2:0] policy_reg;
    logic [7:0] high_reg, mid_reg;
    logic [CNT_W-1:0] count_reg, count_next;
    in_beat_t in_reg, in_next;
    logic [WGT_W-1:0] prod_reg, prod_next;
    logic [CNT_W-1:0] ptr_reg, ptr_next;   // read address issued
    logic [CNT_W-1:0] rptr_reg, rptr_next; // index of data on rdata
    logic             rv_reg, rv_next;
    logic             found_reg, found_next;
    logic [IDX_W-1:0] best_reg, best_next;
    entry_t           be_reg, be_next;
    logic [1:0]       blvl_reg, blvl_next;
    logic             ovalid_reg, ovalid_next;
    out_beat_t        obeat_reg, obeat_next;

    logic             we;
    logic [IDX_W-1:0] waddr, raddr;
    entry_t           wdata, rd;
    logic [$bits(entry_t)-1:0] rraw;
    logic [1:0]       rlvl;
    logic             better;

    tqmps_ram #(.AW(IDX_W), .DW($bits(entry_t))) u_ram (
        .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
        .raddr(raddr), .rdata(rraw)
    );
    assign rd = entry_t'(rraw);

    function automatic logic [1:0] lvl(input logic [7:0] p, input logic [7:0] h,
                                       input logic [7:0] m);
        logic [1:0] r;
        r = (p >= h) ? 2'd0 : ((p >= m) ? 2'd1 : 2'd2);
        return r;
    endfunction

    assign rlvl = lvl(rd.prio, high_reg, mid_reg);

    always_comb
    begin
        better = 1'b0;
        case (policy_reg)
            POL_NEWEST: better = 1'b1;
            POL_PRIO:   better = !found_reg || rd.prio > be_reg.prio;
            POL_LEVEL:  better = !found_reg || rlvl < blvl_reg;
            POL_WEIGHT: better = rd.has_res && (!found_reg || rd.weight < be_reg.weight);
            default:    better = !found_reg;
        endcase
    end

    assign in_stall = (state_reg != S_IDLE) || ovalid_reg;
    assign out_valid = ovalid_reg;
    assign out_data = obeat_reg;

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        in_next = in_reg;
        prod_next = prod_reg;
        ptr_next = ptr_reg;
        rptr_next = rptr_reg;
        rv_next = 1'b0;
        found_next = found_reg;
        best_next = best_reg;
        be_next = be_reg;
        blvl_next = blvl_reg;
        ovalid_next = ovalid_reg && out_stall;
        obeat_next = obeat_reg;
        we = 1'b0;
        waddr = count_reg[IDX_W-1:0];
        wdata = '0;
        raddr = ptr_reg[IDX_W-1:0];
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid && !in_stall)
                begin
                    in_next = in_data;
                    if (in_data.cmd == CMD_PUSH)
                    begin
                        if (count_reg == CNT_W'(DEPTH))
                        begin
                            obeat_next = '{ST_FULL, 16'd0, 8'd0};
                            state_next = S_OUT;
                        end
                        else
                        begin
                            prod_next = WGT_W'(16'(in_data.sub_count) * 16'(in_data.proc_need));
                            state_next = S_WGT;
                        end
                    end
                    else if (count_reg == '0)
                    begin
                        obeat_next = '{ST_NONE, 16'd0, 8'd0};
                        state_next = S_OUT;
                    end
                    else
                    begin
                        found_next = 1'b0;
                        ptr_next = '0;
                        state_next = S_SCAN;
                    end
                end
            end
            S_WGT:
            begin
                we = 1'b1;
                wdata.id = in_reg.task_id;
                wdata.prio = in_reg.priority_req;
                wdata.has_res = in_reg.has_resource;
                wdata.weight = (prod_reg << 2) + (prod_reg << 1)
                             + (WGT_W'(in_reg.mem_need) << 3) + WGT_W'(in_reg.disk_need);
                count_next = count_reg + 1'b1;
                obeat_next = '{ST_DONE, 16'd0, 8'd0};
                state_next = S_OUT;
            end
            S_SCAN:
            begin
                if (ptr_reg != count_reg)
                begin
                    ptr_next = ptr_reg + 1'b1;
                    rv_next = 1'b1;
                    rptr_next = ptr_reg;
                end
                if (rv_reg && better)
                begin
                    found_next = 1'b1;
                    best_next = rptr_reg[IDX_W-1:0];
                    be_next = rd;
                    blvl_next = rlvl;
                end
                if (ptr_reg == count_reg && !rv_reg)
                begin
                    if (!found_reg)
                    begin
                        obeat_next = '{ST_NONE, 16'd0, 8'd0};
                        state_next = S_OUT;
                    end
                    else
                    begin
                        obeat_next = '{ST_DONE, be_reg.id, be_reg.prio};
                        ptr_next = CNT_W'(best_reg) + 1'b1;
                        state_next = S_SHIFT;
                    end
                end
            end
            S_SHIFT:
            begin
                // read ptr, write ptr-1 when data arrives
                if (ptr_reg != count_reg)
                begin
                    ptr_next = ptr_reg + 1'b1;
                    rv_next = 1'b1;
                    rptr_next = ptr_reg;
                end
                if (rv_reg)
                begin
                    we = 1'b1;
                    waddr = IDX_W'(rptr_reg - 1'b1);
                    wdata = rd;
                end
                if (ptr_reg == count_reg && !rv_reg)
                begin
                    count_next = count_reg - 1'b1;
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                ovalid_next = 1'b1;
                state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            ovalid_reg <= 1'b0;
            rv_reg <= 1'b0;
            found_reg <= 1'b0;
            policy_reg <= POL_OLDEST;
            high_reg <= 8'd10;
            mid_reg <= 8'd5;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            ovalid_reg <= ovalid_next;
            rv_reg <= rv_next;
            found_reg <= found_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_POLICY: policy_reg <= cfg_data[2:0];
                    REG_HIGH:   high_reg <= cfg_data;
                    REG_MID:    mid_reg <= cfg_data;
                    default:    ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        in_reg <= in_next;
        prod_reg <= prod_next;
        ptr_reg <= ptr_next;
        rptr_reg <= rptr_next;
        best_reg <= best_next;
        be_reg <= be_next;
        blvl_reg <= blvl_next;
        obeat_reg <= obeat_next;
    end

`ifndef SYNTH
    a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH)) else $error("count overflow");
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> in_stall) else $error("accept while busy");
    a_out_from_out: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(state_reg) == S_OUT) else $error("bad result");
    a_pop_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SHIFT && state_next == S_OUT) |=> count_reg == $past(count_reg) - 1'b1)
        else $error("pop count");
`endif
endmodule
`default_nettype wire
